### hw/rtl/spti_pkg.sv
package spti_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_DUPLICATE = 2'd2,
    STATUS_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  localparam logic CFG_SORT_DESCENDING  = 1'b0;
  localparam logic CFG_ALLOW_DUPLICATES = 1'b1;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;
  localparam int COUNT_W    = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic sort_step;
    logic sort_odd;
    logic sort_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_sort;
    logic out_free;
  } stat_t;

  // True when key a must stand strictly before key b in the given order.
  function automatic logic comes_before(input word_t a, input word_t b, input logic desc);
    logic res;
    res = desc ? (a > b) : (a < b);
    return res;
  endfunction

endpackage

### hw/rtl/spti_ctrl.sv
module spti_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  spti_pkg::stat_t stat,
  output spti_pkg::cmd_t  cmd
);
  import spti_pkg::*;

  localparam int SW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SORT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] pass_r, pass_nxt;
  logic last_pass;

  assign in_tready = (state_r == S_IDLE) && stat.out_free;
  assign last_pass = (pass_r == SW'(CAPACITY - 1));

  always_comb begin
    cmd.capture   = in_tvalid && in_tready;
    cmd.exec      = (state_r == S_EXEC);
    cmd.sort_step = (state_r == S_SORT);
    cmd.sort_odd  = pass_r[0];
    cmd.sort_last = (state_r == S_SORT) && last_pass;
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        pass_nxt = '0;
        if (stat.need_sort) begin
          state_nxt = S_SORT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SORT: begin
        pass_nxt = pass_r + SW'(1);
        if (last_pass) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

### hw/rtl/spti_dp.sv
module spti_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [spti_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [0:0]                           in_tuser,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_index,
  input  logic                                 cfg_data,
  input  spti_pkg::cmd_t                       cmd,
  output spti_pkg::stat_t                      stat,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [spti_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                           out_tuser
);
  import spti_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int XW = (CW > 4) ? CW : 4;

  // Item captured at acceptance.
  logic        act_r;
  word_t       key_r;
  word_t       val_r;
  logic [3:0]  idx_r;

  word_t       keys_r [CAPACITY];
  word_t       vals_r [CAPACITY];
  word_t       keys_nxt [CAPACITY];
  word_t       vals_nxt [CAPACITY];
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic desc_r, allow_dup_r, sorted_desc_r;

  logic          out_valid_r;
  status_t       out_status_r;
  word_t         out_key_r, out_val_r;
  logic [COUNT_W-1:0] out_cnt_r;

  logic [CAPACITY-1:0] live, hit, after;
  logic          full, dup, mismatch, ins_ok, idx_bad, load;
  logic [XW-1:0] idx_x;
  status_t       res_status;
  word_t         rd_key, rd_val;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]  = (CW'(i) < cnt_r);
      hit[i]   = live[i] && ((keys_r[i] == key_r) || (vals_r[i] == val_r));
      after[i] = !live[i] || comes_before(key_r, keys_r[i], desc_r);
    end
  end

  assign full     = (cnt_r == CW'(CAPACITY));
  assign dup      = !allow_dup_r && (|hit);
  assign mismatch = (sorted_desc_r != desc_r) && (cnt_r > CW'(1));
  assign ins_ok   = (act_r == ACT_INSERT) && !full && !dup;
  assign idx_x    = XW'(idx_r);
  assign idx_bad  = (idx_x >= XW'(cnt_r));
  assign rd_key   = keys_r[idx_x[IW-1:0]];
  assign rd_val   = vals_r[idx_x[IW-1:0]];

  assign stat.need_sort = ins_ok && mismatch;
  assign stat.out_free  = !out_valid_r || out_tready;

  // Table update: shift-insert in order, plain append before a re-sort,
  // or one odd-even transposition pass with strict compares (stable).
  always_comb begin
    keys_nxt = keys_r;
    vals_nxt = vals_r;
    cnt_nxt  = cnt_r;
    if (cmd.exec && ins_ok) begin
      cnt_nxt = cnt_r + CW'(1);
      if (mismatch) begin
        keys_nxt[cnt_r[IW-1:0]] = key_r;
        vals_nxt[cnt_r[IW-1:0]] = val_r;
      end else begin
        if (after[0]) begin
          keys_nxt[0] = key_r;
          vals_nxt[0] = val_r;
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (after[i]) begin
            if (!after[i-1]) begin
              keys_nxt[i] = key_r;
              vals_nxt[i] = val_r;
            end else begin
              keys_nxt[i] = keys_r[i-1];
              vals_nxt[i] = vals_r[i-1];
            end
          end
        end
      end
    end else if (cmd.sort_step) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if ((i[0] == cmd.sort_odd) && (CW'(i + 1) < cnt_r) &&
            comes_before(keys_r[i+1], keys_r[i], desc_r)) begin
          keys_nxt[i]   = keys_r[i+1];
          vals_nxt[i]   = vals_r[i+1];
          keys_nxt[i+1] = keys_r[i];
          vals_nxt[i+1] = vals_r[i];
        end
      end
    end
  end

  always_comb begin
    if (act_r == ACT_READ) begin
      res_status = idx_bad ? STATUS_BAD_INDEX : STATUS_OK;
    end else if (full) begin
      res_status = STATUS_FULL;
    end else if (dup) begin
      res_status = STATUS_DUPLICATE;
    end else begin
      res_status = STATUS_OK;
    end
  end

  assign load = (cmd.exec && !stat.need_sort) || cmd.sort_last;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_tuser[0];
      key_r <= in_tdata[31:0];
      val_r <= in_tdata[63:32];
      idx_r <= in_tdata[67:64];
    end
    keys_r <= keys_nxt;
    vals_r <= vals_nxt;
    if (cmd.sort_last) begin
      out_status_r <= STATUS_OK;
      out_key_r    <= '0;
      out_val_r    <= '0;
      out_cnt_r    <= COUNT_W'(cnt_r);
    end else if (cmd.exec) begin
      out_status_r <= res_status;
      out_cnt_r    <= COUNT_W'(cnt_nxt);
      if ((act_r == ACT_READ) && !idx_bad) begin
        out_key_r <= rd_key;
        out_val_r <= rd_val;
      end else begin
        out_key_r <= '0;
        out_val_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      desc_r        <= 1'b0;
      allow_dup_r   <= 1'b1;
      sorted_desc_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.exec && ins_ok) begin
        sorted_desc_r <= desc_r;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SORT_DESCENDING:  desc_r      <= cfg_data;
          CFG_ALLOW_DUPLICATES: allow_dup_r <= cfg_data;
          default: ;
        endcase
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_val_r, out_key_r};

endmodule

### hw/rtl/sorted_pair_table_insert.sv
// Sorted table of up to CAPACITY signed (key, value) pairs, kept in ascending
// or descending key order, with stable placement of equal keys. Each input
// word is an insert or a read and yields exactly one output word carrying a
// status, the read pair and the entry count after the word. A read, a refused
// insert and an insert in the current order are first accepted into a capture
// register; then, in the exec state, every stored entry is compared with the
// new key at once and the table shifts to make room. The first accepted insert
// after the sort order was changed with two or more entries stored is appended
// and the table is then re-sorted with odd-even transposition passes, one
// pass a cycle. Only one word is in flight at a time; the next one is taken
// once the result register is free or being drained. Configuration words are
// always accepted and must be sent only while the block is idle.
module sorted_pair_table_insert #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spti_pkg::IN_DATA_W-1:0]   in_tdata,   // key[31:0], value[63:32], index[67:64]
  input  logic [0:0]                       in_tuser,   // action[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spti_pkg::OUT_DATA_W-1:0]  out_tdata,  // key_out[31:0], value_out[63:32],
                                                       // count[68:64]
  output logic [1:0]                       out_tuser,  // status[1:0]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic                             cfg_data
);
  import spti_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  spti_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spti_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  // The compare-and-shift cycle always directly follows an accepted word.
  a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(cmd.capture))
    else $error("exec without a preceding accepted word");

  // No word is taken while a re-sort is running.
  a_no_accept_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sort_step |-> !in_tready)
    else $error("input ready during re-sort");

  // A new result appears only after an exec cycle or the last sort pass.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.exec || cmd.sort_last))
    else $error("result word without a finished operation");
`endif

endmodule

### tb/testbench.sv
module testbench;
  import spti_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int WORDS_PER_PHASE = 40;
  localparam word_t EXTREMES [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

  typedef enum logic [1:0] {
    STEP_WORD,
    STEP_CONFIG,
    STEP_WAIT_IDLE
  } step_kind_t;

  typedef struct {
    step_kind_t kind;
    action_t    action;
    word_t      key;
    word_t      value;
    logic [3:0] index;
    logic       reg_index;
    logic       reg_value;
    int         gap;
  } stimulus_step_t;

  typedef struct {
    status_t    status;
    word_t      key_out;
    word_t      value_out;
    logic [4:0] count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic                  cfg_data = 1'b0;

  sorted_pair_table_insert #(
    .CAPACITY(TABLE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the table and its settings.
  word_t table_keys [TABLE_DEPTH];
  word_t table_vals [TABLE_DEPTH];
  int    table_count = 0;
  logic  order_desc = 1'b0;
  logic  dups_allowed = 1'b1;

  stimulus_step_t pending_steps[$];
  table_result_t  table_results_due[$];

  int mismatches = 0;
  int words_sent = 0;
  int cfg_writes = 0;
  int results_seen = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  int cycles = 0;

  function automatic logic key_precedes(input word_t a, input word_t b);
    return order_desc ? (a > b) : (a < b);
  endfunction

  // Applies one word to the shadow table and returns the result it must produce.
  function automatic table_result_t apply_table_op(input stimulus_step_t op);
    table_result_t r;
    logic          dup;
    int            i;
    int            j;
    word_t         k;
    word_t         v;
    r.status    = STATUS_OK;
    r.key_out   = '0;
    r.value_out = '0;
    if (op.action == ACT_INSERT) begin
      if (table_count >= TABLE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        dup = 1'b0;
        if (!dups_allowed) begin
          for (i = 0; i < table_count; i++) begin
            if (table_keys[i] == op.key || table_vals[i] == op.value) dup = 1'b1;
          end
        end
        if (dup) begin
          r.status = STATUS_DUPLICATE;
        end else begin
          table_keys[table_count] = op.key;
          table_vals[table_count] = op.value;
          table_count++;
          // Stable insertion sort in the current order; this also re-sorts
          // entries stored under the other order.
          for (i = 1; i < table_count; i++) begin
            k = table_keys[i];
            v = table_vals[i];
            j = i;
            while (j > 0 && key_precedes(k, table_keys[j-1])) begin
              table_keys[j] = table_keys[j-1];
              table_vals[j] = table_vals[j-1];
              j--;
            end
            table_keys[j] = k;
            table_vals[j] = v;
          end
        end
      end
    end else if (int'(op.index) >= table_count) begin
      r.status = STATUS_BAD_INDEX;
    end else begin
      r.key_out   = table_keys[op.index];
      r.value_out = table_vals[op.index];
    end
    r.count = table_count[4:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t pick_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return word_t'($urandom_range(0, 8)) - 32'sd4;
    if (r < 60) return EXTREMES[$urandom_range(0, 3)];
    return word_t'($urandom);
  endfunction

  task automatic queue_word(input action_t act, input word_t key, input word_t value,
                            input logic [3:0] index, input int gap);
    stimulus_step_t s;
    s.kind = STEP_WORD;
    s.action = act;
    s.key = key;
    s.value = value;
    s.index = index;
    s.reg_index = 1'b0;
    s.reg_value = 1'b0;
    s.gap = gap;
    pending_steps.insert(pending_steps.size(), s);
  endtask

  task automatic queue_config(input logic reg_index, input logic reg_value);
    stimulus_step_t s;
    s.kind = STEP_CONFIG;
    s.action = ACT_INSERT;
    s.key = '0;
    s.value = '0;
    s.index = '0;
    s.reg_index = reg_index;
    s.reg_value = reg_value;
    s.gap = 0;
    pending_steps.insert(pending_steps.size(), s);
  endtask

  task automatic queue_idle_wait();
    stimulus_step_t s;
    s.kind = STEP_WAIT_IDLE;
    s.action = ACT_INSERT;
    s.key = '0;
    s.value = '0;
    s.index = '0;
    s.reg_index = 1'b0;
    s.reg_value = 1'b0;
    s.gap = 0;
    pending_steps.insert(pending_steps.size(), s);
  endtask

  // Word and register driver.
  stimulus_step_t in_flight;
  int gap_left = 0;
  int idle_run = 0;

  always @(posedge clk) begin : word_driver
    logic word_held;
    logic cfg_held;
    logic next_in_valid;
    logic next_cfg_valid;
    stimulus_step_t step;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      idle_run = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        table_results_due.insert(table_results_due.size(), apply_table_op(in_flight));
        words_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SORT_DESCENDING) order_desc = cfg_data;
        else dups_allowed = cfg_data;
        cfg_writes++;
      end
      word_held = in_tvalid && !in_tready;
      cfg_held = cfg_valid && !cfg_ready;
      next_in_valid = word_held;
      next_cfg_valid = cfg_held;
      if (table_results_due.size() == 0 && !in_tvalid && !cfg_valid) idle_run++;
      else idle_run = 0;
      if (!word_held && !cfg_held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_steps.size() != 0) begin
          step = pending_steps[0];
          case (step.kind)
            STEP_WORD: begin
              step = pending_steps.pop_front();
              in_tdata <= {4'b0, step.index, step.value, step.key};
              in_tuser <= step.action;
              in_flight = step;
              next_in_valid = 1'b1;
              gap_left = step.gap;
            end
            STEP_CONFIG: begin
              if (idle_run >= 4) begin
                step = pending_steps.pop_front();
                cfg_index <= step.reg_index;
                cfg_data <= step.reg_value;
                next_cfg_valid = 1'b1;
              end
            end
            default: begin
              if (idle_run >= 4) step = pending_steps.pop_front();
            end
          endcase
        end
      end
      in_tvalid <= next_in_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  // Result checker with its own stall pattern on out_tready.
  int stall_left = 0;
  int stall_mode = 0;
  int mode_cycles = 0;

  always @(posedge clk) begin : result_checker
    table_result_t want;
    logic ready_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        status_hits[out_tuser]++;
        if (table_results_due.size() == 0) begin
          $display("%0t: result word with none expected: status %0d count %0d", $time,
                   out_tuser, out_tdata[68:64]);
          mismatches++;
        end else begin
          want = table_results_due.pop_front();
          if (out_tuser !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_tuser);
            mismatches++;
          end
          if (out_tdata[31:0] !== want.key_out) begin
            $display("%0t: key_out expected %0d got %0d", $time, want.key_out,
                     $signed(out_tdata[31:0]));
            mismatches++;
          end
          if (out_tdata[63:32] !== want.value_out) begin
            $display("%0t: value_out expected %0d got %0d", $time, want.value_out,
                     $signed(out_tdata[63:32]));
            mismatches++;
          end
          if (out_tdata[68:64] !== want.count) begin
            $display("%0t: count expected %0d got %0d", $time, want.count, out_tdata[68:64]);
            mismatches++;
          end
        end
      end
      // When the mode_cycles counter wraps, pick between no stalls, light stalls and heavy stalls.
      mode_cycles++;
      if (mode_cycles >= 100) begin
        mode_cycles = 0;
        stall_mode = $urandom_range(0, 2);
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if (stall_mode == 1 && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 3);
        end else if (stall_mode == 2 && $urandom_range(0, 2) == 0) begin
          stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 4);
        end
        if (stall_left > 0) begin
          stall_left--;
          ready_next = 1'b0;
        end
      end
      out_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               table_results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int combo;
    logic quiet;
    logic want_desc;
    logic want_dups;

    // Empty table, then extreme keys and values with one pair of equal keys.
    queue_word(ACT_READ, 32'h0, 32'h0, 4'd0, pick_gap());
    queue_word(ACT_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, pick_gap());
    queue_word(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd0, pick_gap());
    queue_word(ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 4'd15, pick_gap());
    queue_word(ACT_INSERT, 32'h0, 32'h8000_0000, 4'd0, pick_gap());
    queue_word(ACT_INSERT, 32'h0, 32'sd5, 4'd0, pick_gap());
    queue_word(ACT_INSERT, 32'hFFFF_FFFF, 32'h0, 4'd0, pick_gap());
    for (n = 0; n < 6; n++) queue_word(ACT_READ, 32'h0, 32'h0, 4'(n), pick_gap());

    // Flipping the order leaves the table alone until the next insert re-sorts it.
    queue_idle_wait();
    queue_config(CFG_SORT_DESCENDING, 1'b1);
    queue_word(ACT_READ, 32'h0, 32'h0, 4'd0, pick_gap());
    queue_word(ACT_INSERT, 32'sd1, 32'sd1, 4'd0, pick_gap());
    for (n = 0; n < 6; n++) queue_word(ACT_READ, 32'h0, 32'h0, 4'(n), pick_gap());

    // Refusals on an equal key, on an equal value, then an accepted unique pair.
    queue_idle_wait();
    queue_config(CFG_ALLOW_DUPLICATES, 1'b0);
    queue_word(ACT_INSERT, 32'h0, 32'sd100, 4'd0, pick_gap());
    queue_word(ACT_INSERT, 32'sd77, 32'sd5, 4'd0, pick_gap());
    queue_word(ACT_INSERT, 32'sd77, 32'sd77, 4'd0, pick_gap());
    queue_word(ACT_READ, 32'h0, 32'h0, 4'd1, pick_gap());

    // Random phases; the first four go through every register setting.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      combo = (phase < 4) ? phase : $urandom_range(0, 3);
      want_desc = combo[0];
      want_dups = combo[1];
      quiet = (phase % 3 == 0);
      queue_idle_wait();
      queue_config(CFG_SORT_DESCENDING, want_desc);
      queue_config(CFG_ALLOW_DUPLICATES, want_dups);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 14) begin
          queue_word(ACT_INSERT, pick_operand(), pick_operand(), 4'($urandom_range(0, 15)),
                     quiet ? 0 : pick_gap());
        end else begin
          queue_word(ACT_READ, word_t'($urandom), word_t'($urandom),
                     $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 7)),
                     quiet ? 0 : pick_gap());
        end
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled away from the rising edge so that the driver's updates have settled.
    while (pending_steps.size() != 0 || in_tvalid || cfg_valid ||
           table_results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("Sent %0d table words and %0d register writes, checked %0d result words.",
             words_sent, cfg_writes, results_seen);
    $display("Outcomes: %0d ok, %0d full, %0d duplicate, %0d bad index; %0d mismatches.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], mismatches);
    if (mismatches == 0 && table_results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
